// ===== design/i2cbm_pkg.sv =====
`default_nettype none
package i2cbm_pkg;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6,
        CMD_WAIT  = 3'd7
    } cmd_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd255;

    typedef struct packed {
        cmd_t       cmd;
        logic       new_cmd;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_item_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic [7:0] rx_byte;
        logic ack_seen;
    } tick_result_t;

endpackage
`default_nettype wire

// ===== design/i2cbm_front.sv =====
`default_nettype none
module i2cbm_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [2:0]             s_action,
    input  wire  [7:0]             s_tx_byte,
    input  wire                    s_sda_in,
    output logic                   q_valid,
    output i2cbm_pkg::tick_item_t  q_item,
    input  wire                    q_pop
);
    import i2cbm_pkg::*;

    tick_item_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    tick_item_t            item_in;
    logic                  push;
    logic                  pop;

    always_comb begin
        item_in.cmd     = cmd_t'(s_action);
        item_in.new_cmd = (cmd_t'(s_action) != CMD_IDLE);
        item_in.tx_byte = s_tx_byte;
        item_in.sda_in  = s_sda_in;
    end

    assign s_tready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== design/i2cbm_engine.sv =====
`default_nettype none
module i2cbm_engine (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_valid,
    input  wire  [15:0]            cfg_data,
    input  wire                    q_valid,
    input  i2cbm_pkg::tick_item_t  q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output i2cbm_pkg::tick_result_t m_result
);
    import i2cbm_pkg::*;

    cmd_t         cmd_reg, cmd_next;
    logic [2:0]   phase_reg, phase_next;
    logic [2:0]   bit_index_reg, bit_index_next;
    logic [7:0]   shift_reg, shift_next;
    logic [15:0]  timeout_reg, timeout_next;
    logic         scl_reg, scl_next;
    logic         sda_reg, sda_next;
    logic         ack_reg, ack_next;
    logic [7:0]   rx_reg, rx_next;
    logic [15:0]  ack_timeout_reg;
    logic         out_valid_reg;
    tick_result_t out_reg, out_next;
    logic         active;
    logic         fin;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        timeout_next   = timeout_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        rx_next        = rx_reg;
        fin            = 1'b0;
        active         = 1'b0;

        if (cmd_reg == CMD_IDLE && q_item.new_cmd) begin
            cmd_next       = q_item.cmd;
            phase_next     = 3'd0;
            bit_index_next = 3'd7;
            if (q_item.cmd == CMD_WRITE) shift_next = q_item.tx_byte;
            if (q_item.cmd == CMD_READ) rx_next = 8'd0;
            if (q_item.cmd == CMD_WAIT) timeout_next = ack_timeout_reg;
        end

        if (cmd_next != CMD_IDLE) begin
            active = 1'b1;
            case (cmd_next)
                CMD_START: begin
                    if (phase_next == 3'd0) begin
                        sda_next = 1'b0;
                        phase_next = 3'd1;
                    end else begin
                        scl_next = 1'b0;
                        fin = 1'b1;
                    end
                end
                CMD_STOP: begin
                    if (phase_next == 3'd0) begin
                        scl_next = 1'b1;
                        phase_next = 3'd1;
                    end else begin
                        sda_next = 1'b1;
                        fin = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    case (phase_next)
                        3'd0: begin
                            sda_next = shift_next[bit_index_next];
                            phase_next = 3'd1;
                        end
                        3'd1: begin
                            scl_next = 1'b1;
                            phase_next = 3'd2;
                        end
                        3'd2: phase_next = 3'd3;
                        default: begin
                            scl_next = 1'b0;
                            if (bit_index_next == 3'd0) begin
                                fin = 1'b1;
                            end else begin
                                bit_index_next = bit_index_next - 3'd1;
                                phase_next = 3'd0;
                            end
                        end
                    endcase
                end
                CMD_READ: begin
                    sda_next = 1'b1;
                    case (phase_next)
                        3'd0: begin
                            scl_next = 1'b0;
                            phase_next = 3'd1;
                        end
                        3'd1: begin
                            scl_next = 1'b1;
                            phase_next = 3'd2;
                        end
                        3'd2: begin
                            if (q_item.sda_in) rx_next[bit_index_next] = 1'b1;
                            phase_next = 3'd3;
                        end
                        default: begin
                            scl_next = 1'b0;
                            if (bit_index_next == 3'd0) begin
                                fin = 1'b1;
                            end else begin
                                bit_index_next = bit_index_next - 3'd1;
                                phase_next = 3'd0;
                            end
                        end
                    endcase
                end
                CMD_ACK: begin
                    case (phase_next)
                        3'd0: begin
                            sda_next = 1'b1;
                            phase_next = 3'd1;
                        end
                        3'd1: begin
                            scl_next = 1'b1;
                            phase_next = 3'd2;
                        end
                        default: begin
                            scl_next = 1'b0;
                            sda_next = 1'b1;
                            fin = 1'b1;
                        end
                    endcase
                end
                CMD_NACK: begin
                    case (phase_next)
                        3'd0: begin
                            sda_next = 1'b1;
                            phase_next = 3'd1;
                        end
                        3'd1: begin
                            scl_next = 1'b1;
                            phase_next = 3'd2;
                        end
                        3'd2: phase_next = 3'd3;
                        3'd3: begin
                            scl_next = 1'b0;
                            phase_next = 3'd4;
                        end
                        default: begin
                            sda_next = 1'b0;
                            fin = 1'b1;
                        end
                    endcase
                end
                CMD_WAIT: begin
                    case (phase_next)
                        3'd0, 3'd1: begin
                            sda_next = 1'b1;
                            phase_next = phase_next + 3'd1;
                        end
                        3'd2: begin
                            scl_next = 1'b1;
                            if (!q_item.sda_in) begin
                                ack_next = 1'b1;
                                phase_next = 3'd3;
                            end else if (timeout_next == 16'd0) begin
                                ack_next = 1'b0;
                                phase_next = 3'd3;
                            end else begin
                                timeout_next = timeout_next - 16'd1;
                            end
                        end
                        3'd3: begin
                            scl_next = 1'b0;
                            phase_next = 3'd4;
                        end
                        3'd4: begin
                            sda_next = 1'b1;
                            phase_next = 3'd5;
                        end
                        default: begin
                            sda_next = 1'b0;
                            fin = 1'b1;
                        end
                    endcase
                end
                default: ;
            endcase
            if (fin) begin
                cmd_next       = CMD_IDLE;
                phase_next     = 3'd0;
                bit_index_next = 3'd7;
            end
        end

        out_next.scl      = scl_next;
        out_next.sda      = sda_next;
        out_next.busy     = active && !fin;
        out_next.done     = fin;
        out_next.rx_byte  = rx_next;
        out_next.ack_seen = ack_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg         <= CMD_IDLE;
            phase_reg       <= 3'd0;
            bit_index_reg   <= 3'd7;
            shift_reg       <= 8'd0;
            timeout_reg     <= 16'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ack_reg         <= 1'b0;
            rx_reg          <= 8'd0;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ack_timeout_reg <= cfg_data;
            end
            if (q_pop) begin
                cmd_reg       <= cmd_next;
                phase_reg     <= phase_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                timeout_reg   <= timeout_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                ack_reg       <= ack_next;
                rx_reg        <= rx_next;
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/i2c_bit_level_master_unit.sv =====
// Bit-level I2C master: one request is one bus delay tick and yields one result.
// One request per cycle unless m_tready stalls; the tick engine updates all line state at once.
// m_tvalid rises once an accepted request has been written into the two-entry queue and then
// computed into the result register, which happens only while the output slot is free.
// Reset (aresetn low, synchronous) idles the engine with both lines released, empties the
// queue, drops m_tvalid and restores the ack timeout to 255.
`default_nettype none
module i2c_bit_level_master_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data,   // ack_timeout
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,    // tx_byte[7:0], sda_in[8], zero fill
    input  wire  [2:0]  s_tuser,    // action[2:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata     // scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen
);
    import i2cbm_pkg::*;

    logic         q_valid;
    logic         q_pop;
    tick_item_t   q_item;
    tick_result_t result;

    assign cfg_ready = 1'b1;

    i2cbm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_action  (s_tuser),
        .s_tx_byte (s_tdata[7:0]),
        .s_sda_in  (s_tdata[8]),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2cbm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    assign m_tdata = {3'b000, result.ack_seen, result.rx_byte,
                      result.done, result.busy, result.sda, result.scl};

    a_busy_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("busy and done reported together");

    a_enqueue_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !q_valid) |=> q_valid)
        else $error("accepted request not visible in queue");

    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_valid && (!m_tvalid || m_tready)))
        else $error("engine consumed a request without an output slot");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
